// File: rtl/core/bfsa_pkg.sv
// ----------------------------------------------------------------------------
// bfsa_pkg: shared types and constants for the best-fit segment allocator
// Sizes, action and status codes, the segment record and cell command struct.
// ----------------------------------------------------------------------------
package bfsa_pkg;

  localparam int unsigned MaxSegments = 16;
  localparam int unsigned AddrBits    = 16;
  localparam int unsigned TimeBits    = 32;
  localparam int unsigned IdxBits     = $clog2(MaxSegments);
  localparam int unsigned CntBits     = $clog2(MaxSegments + 1);

  localparam logic [1:0] ActAlloc   = 2'd0;
  localparam logic [1:0] ActFree    = 2'd1;
  localparam logic [1:0] ActTime    = 2'd2;
  localparam logic [1:0] ActCompact = 2'd3;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StNoFit   = 3'd1;
  localparam logic [2:0] StNoId    = 3'd2;
  localparam logic [2:0] StDupId   = 3'd3;
  localparam logic [2:0] StFull    = 3'd4;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] size;
    logic [15:0]         owner;
    logic [TimeBits-1:0] left;
  } seg_t;

  // Per-cycle command to every cell of the row
  typedef struct packed {
    logic                shift_up;   // take left neighbor's record (insert)
    logic                shift_dn;   // take right neighbor's record (remove)
    logic [IdxBits-1:0]  pivot;      // index where insert/remove happens
    logic                load;       // write new record at pivot
    seg_t                rec;        // new record
    logic                age;        // subtract elapsed from cell at pivot
    logic [TimeBits-1:0] elapsed;
    logic                set_start;  // overwrite start at pivot
    logic [AddrBits-1:0] new_start;
  } cell_cmd_t;

endpackage

// File: rtl/core/bfsa_cell.sv
// ----------------------------------------------------------------------------
// bfsa_cell: one table slot of the segment row
// Holds one segment record; shifts with its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module bfsa_cell (
  input  logic                          clk_i,
  input  logic [bfsa_pkg::IdxBits-1:0]  idx_i,
  input  bfsa_pkg::cell_cmd_t           cmd_i,
  input  bfsa_pkg::seg_t                left_i,
  input  bfsa_pkg::seg_t                right_i,
  output bfsa_pkg::seg_t                seg_o
);

  bfsa_pkg::seg_t seg_q, seg_d;

  // next record from the row command
  always_comb begin
    seg_d = seg_q;
    if (cmd_i.shift_up && idx_i > cmd_i.pivot) begin
      seg_d = left_i;
    end else if (cmd_i.shift_dn && idx_i >= cmd_i.pivot) begin
      seg_d = right_i;
    end
    if (idx_i == cmd_i.pivot) begin
      if (cmd_i.load) begin
        seg_d = cmd_i.rec;
      end
      if (cmd_i.age) begin
        seg_d.left = seg_q.left - cmd_i.elapsed;
      end
      if (cmd_i.set_start) begin
        seg_d.start = cmd_i.new_start;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
  end

  assign seg_o = seg_q;

endmodule

// File: rtl/core/best_fit_segment_allocator_core.sv
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_core: best-fit allocator over a row of slot cells
// Sequencer walks the segment table one slot per cycle.
// ----------------------------------------------------------------------------
// Allocate and free scan the table and then insert or remove a record; time
// step and compact walk the occupied slots. busy is high from
// accept until the result strobe; one request at a time. The walk over the
// cell row goes one slot a cycle. Reset empties the table and
// sets total memory to 65535; the receiver cannot stall a result.
module best_fit_segment_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [15:0] process_id_i,
  input  logic [15:0] process_size_i,
  input  logic [31:0] lifetime_i,
  input  logic [31:0] elapsed_time_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [15:0] position_o,
  output logic [15:0] free_memory_o,
  output logic [4:0]  removed_count_o,
  output logic        running_o
);

  localparam int unsigned N  = bfsa_pkg::MaxSegments;
  localparam int unsigned IB = bfsa_pkg::IdxBits;
  localparam int unsigned CB = bfsa_pkg::CntBits;
  localparam int unsigned AB = bfsa_pkg::AddrBits;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;  // id search / gap search
  localparam logic [2:0] SAct   = 3'd2;  // insert or remove
  localparam logic [2:0] STime  = 3'd3;
  localparam logic [2:0] SComp  = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [15:0] total_q;
  logic [CB-1:0] count_q, count_d;
  logic [AB-1:0] used_q, used_d;
  logic [CB-1:0] k_q, k_d;           // walk index, up to count
  logic [1:0]  act_q;
  logic [15:0] id_q;
  logic [AB-1:0] need_q;
  logic [31:0] life_q, elapsed_q;
  logic        hit_q, hit_d;
  logic [IB-1:0] hit_idx_q, hit_idx_d;
  logic        found_q, found_d;
  logic [CB-1:0] best_i_q, best_i_d;
  logic [AB-1:0] best_sz_q, best_sz_d, best_st_q, best_st_d;
  logic [AB-1:0] lo_q, lo_d;         // end of previous segment / compact cursor
  logic [2:0]  status_q, status_d;
  logic [AB-1:0] pos_q, pos_d;
  logic [4:0]  rem_q, rem_d;

  bfsa_pkg::cell_cmd_t cmd;
  bfsa_pkg::seg_t      seg [N];
  bfsa_pkg::seg_t      zero_seg;
  bfsa_pkg::seg_t      cur;

  assign zero_seg = '0;

  // row of slot cells
  for (genvar g = 0; g < N; g++) begin : g_cell
    bfsa_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IB'(g)),
      .cmd_i   (cmd),
      .left_i  ((g == 0) ? zero_seg : seg[(g == 0) ? 0 : g-1]),
      .right_i ((g == N-1) ? zero_seg : seg[(g == N-1) ? g : g+1]),
      .seg_o   (seg[g])
    );
  end

  assign cur = seg[k_q[IB-1:0]];

  // gap at walk index k_q during allocate scan
  logic [AB:0]   hi_w;
  logic [AB-1:0] gap;
  always_comb begin
    hi_w = (k_q == count_q) ? {1'b0, total_q} : {1'b0, cur.start};
    gap  = (hi_w > {1'b0, lo_q}) ? AB'(hi_w - {1'b0, lo_q}) : '0;
  end

  // sequencer
  always_comb begin
    state_d = state_q; count_d = count_q; used_d = used_q; k_d = k_q;
    hit_d = hit_q; hit_idx_d = hit_idx_q; found_d = found_q;
    best_i_d = best_i_q; best_sz_d = best_sz_q; best_st_d = best_st_q;
    lo_d = lo_q; status_d = status_q; pos_d = pos_q; rem_d = rem_q;
    cmd = '0;
    cmd.rec = '0;
    case (state_q)
      SIdle: begin
        if (start) begin
          k_d = '0; hit_d = 1'b0; found_d = 1'b0; lo_d = '0;
          status_d = bfsa_pkg::StOk; pos_d = '0; rem_d = '0;
          case (action_i)
            bfsa_pkg::ActTime:    state_d = STime;
            bfsa_pkg::ActCompact: state_d = SComp;
            default:              state_d = SScan;
          endcase
        end
      end
      SScan: begin
        // id search over occupied slots, gap search over count+1 gaps
        if (k_q < count_q && cur.owner == id_q && !hit_q) begin
          hit_d = 1'b1; hit_idx_d = k_q[IB-1:0];
        end
        if (act_q == bfsa_pkg::ActAlloc && gap >= need_q && need_q != '0 &&
            (!found_q || gap < best_sz_q)) begin
          found_d = 1'b1; best_i_d = k_q; best_sz_d = gap; best_st_d = lo_q;
        end
        lo_d = cur.start + cur.size;
        k_d  = k_q + 1'b1;
        if (k_q == count_q) begin
          state_d = SAct;
        end
      end
      SAct: begin
        state_d = SDone;
        if (act_q == bfsa_pkg::ActAlloc) begin
          if (hit_q) status_d = bfsa_pkg::StDupId;
          else if (count_q >= CB'(N)) status_d = bfsa_pkg::StFull;
          else if (!found_q) status_d = bfsa_pkg::StNoFit;
          else begin
            cmd.shift_up = 1'b1; cmd.load = 1'b1;
            cmd.pivot = best_i_q[IB-1:0];
            cmd.rec.start = best_st_q; cmd.rec.size = need_q;
            cmd.rec.owner = id_q; cmd.rec.left = life_q;
            count_d = count_q + 1'b1; used_d = used_q + need_q;
            pos_d = best_st_q;
          end
        end else begin
          if (!hit_q) status_d = bfsa_pkg::StNoId;
          else begin
            cmd.shift_dn = 1'b1; cmd.pivot = hit_idx_q;
            count_d = count_q - 1'b1; used_d = used_q - seg[hit_idx_q].size;
            rem_d = 5'd1;
          end
        end
      end
      STime: begin
        if (k_q >= count_q) state_d = SDone;
        else if (cur.left <= elapsed_q) begin
          cmd.shift_dn = 1'b1; cmd.pivot = k_q[IB-1:0];
          count_d = count_q - 1'b1; used_d = used_q - cur.size;
          rem_d = rem_q + 1'b1;
        end else begin
          cmd.age = 1'b1; cmd.elapsed = elapsed_q; cmd.pivot = k_q[IB-1:0];
          k_d = k_q + 1'b1;
        end
      end
      SComp: begin
        if (k_q >= count_q) state_d = SDone;
        else begin
          cmd.set_start = 1'b1; cmd.new_start = lo_q; cmd.pivot = k_q[IB-1:0];
          lo_d = lo_q + cur.size;
          k_d = k_q + 1'b1;
        end
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; total_q <= 16'hFFFF; count_q <= '0; used_q <= '0;
    end else begin
      state_q <= state_d; count_q <= count_d; used_q <= used_d;
      if (cfg_we_i) total_q <= cfg_wdata_i;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    k_q <= k_d; hit_q <= hit_d; hit_idx_q <= hit_idx_d; found_q <= found_d;
    best_i_q <= best_i_d; best_sz_q <= best_sz_d; best_st_q <= best_st_d;
    lo_q <= lo_d; status_q <= status_d; pos_q <= pos_d; rem_q <= rem_d;
    if (state_q == SIdle && start) begin
      act_q <= action_i; id_q <= process_id_i; need_q <= process_size_i;
      life_q <= lifetime_i; elapsed_q <= elapsed_time_i;
    end
  end

  assign busy            = (state_q != SIdle);
  assign done_o          = (state_q == SDone);
  assign status_o        = status_q;
  assign position_o      = pos_q;
  assign free_memory_o   = (total_q > used_q) ? total_q - used_q : '0;
  assign removed_count_o = rem_q;
  assign running_o       = (count_q != '0);

endmodule

// File: sim/best_fit_segment_allocator_core_test.sv
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_core_test: self-checking bench for the allocator
// Walks a directed table of requests, then random allocate/free/time/compact
// traffic under several memory sizes and idle patterns. Every result is
// compared field by field against an in-bench segment table model or typed row values.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] position;
    logic [15:0] free_memory;
    logic [4:0]  removed_count;
    logic        running;
  } result_t;

  typedef struct {
    logic [1:0]  action;
    logic [15:0] id;
    logic [15:0] size;
    logic [31:0] life;
    logic [31:0] elapsed;
    bit          typed;      // status/position/free given below
    logic [2:0]  status;
    logic [15:0] position;
    logic [15:0] free_memory;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        start;
  logic        busy;
  logic [1:0]  action_i;
  logic [15:0] process_id_i;
  logic [15:0] process_size_i;
  logic [31:0] lifetime_i;
  logic [31:0] elapsed_time_i;
  logic        done_o;
  logic [2:0]  status_o;
  logic [15:0] position_o;
  logic [15:0] free_memory_o;
  logic [4:0]  removed_count_o;
  logic        running_o;

  best_fit_segment_allocator_core DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .start, .busy,
    .action_i, .process_id_i, .process_size_i, .lifetime_i, .elapsed_time_i,
    .done_o, .status_o, .position_o, .free_memory_o, .removed_count_o,
    .running_o
  );

  // Shadow segment table
  logic [15:0] mem_total;
  logic [15:0] seg_start [bfsa_pkg::MaxSegments];
  logic [15:0] seg_size  [bfsa_pkg::MaxSegments];
  logic [15:0] seg_owner [bfsa_pkg::MaxSegments];
  logic [31:0] seg_left  [bfsa_pkg::MaxSegments];
  int unsigned seg_cnt;
  logic [15:0] mem_used;

  result_t pending_results [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int find_seg(input logic [15:0] id);
    for (int k = 0; k < seg_cnt; k++) if (seg_owner[k] == id) return k;
    return -1;
  endfunction

  function automatic void drop_seg(input int k);
    mem_used = mem_used - seg_size[k];
    for (int j = k; j + 1 < seg_cnt; j++) begin
      seg_start[j] = seg_start[j+1];
      seg_size[j]  = seg_size[j+1];
      seg_owner[j] = seg_owner[j+1];
      seg_left[j]  = seg_left[j+1];
    end
    seg_cnt--;
  endfunction

  // Apply one request to the shadow table and return the expected result
  function automatic result_t apply_request(input logic [1:0] act,
      input logic [15:0] id, input logic [15:0] size,
      input logic [31:0] life, input logic [31:0] el);
    result_t r;
    int f;
    longint lo, hi, gap, best_gap;
    int best_k;
    logic [15:0] pos;
    r = '0;
    case (act)
      bfsa_pkg::ActAlloc: begin
        if (find_seg(id) >= 0) r.status = bfsa_pkg::StDupId;
        else if (seg_cnt >= bfsa_pkg::MaxSegments) r.status = bfsa_pkg::StFull;
        else if (size == 0) r.status = bfsa_pkg::StNoFit;
        else begin
          best_k = -1;
          best_gap = 0;
          for (int k = 0; k <= seg_cnt; k++) begin
            lo = (k == 0) ? 0 : longint'(seg_start[k-1]) + seg_size[k-1];
            hi = (k == seg_cnt) ? longint'(mem_total) : longint'(seg_start[k]);
            gap = (hi > lo) ? hi - lo : 0;
            if (gap >= size && (best_k < 0 || gap < best_gap)) begin
              best_k = k;
              best_gap = gap;
            end
          end
          if (best_k < 0) r.status = bfsa_pkg::StNoFit;
          else begin
            pos = (best_k == 0) ? 16'd0 : seg_start[best_k-1] + seg_size[best_k-1];
            for (int k = seg_cnt; k > best_k; k--) begin
              seg_start[k] = seg_start[k-1];
              seg_size[k]  = seg_size[k-1];
              seg_owner[k] = seg_owner[k-1];
              seg_left[k]  = seg_left[k-1];
            end
            seg_start[best_k] = pos;
            seg_size[best_k]  = size;
            seg_owner[best_k] = id;
            seg_left[best_k]  = life;
            seg_cnt++;
            mem_used = mem_used + size;
            r.status = bfsa_pkg::StOk;
            r.position = pos;
          end
        end
      end
      bfsa_pkg::ActFree: begin
        f = find_seg(id);
        if (f < 0) r.status = bfsa_pkg::StNoId;
        else begin
          drop_seg(f);
          r.removed_count = 5'd1;
        end
      end
      bfsa_pkg::ActTime: begin
        f = 0;
        while (f < seg_cnt) begin
          if (seg_left[f] <= el) begin
            drop_seg(f);
            r.removed_count++;
          end else begin
            seg_left[f] -= el;
            f++;
          end
        end
      end
      default: begin
        pos = 16'd0;
        for (int k = 0; k < seg_cnt; k++) begin
          seg_start[k] = pos;
          pos = pos + seg_size[k];
        end
      end
    endcase
    r.free_memory = (mem_total > mem_used) ? mem_total - mem_used : 16'd0;
    r.running = (seg_cnt > 0);
    return r;
  endfunction

  // Result checker: oldest expectation against each strobe
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) begin
          $error("status expected %0d got %0d", e.status, status_o); errors++;
        end
        if (position_o !== e.position) begin
          $error("position expected %0d got %0d", e.position, position_o); errors++;
        end
        if (free_memory_o !== e.free_memory) begin
          $error("free_memory expected %0d got %0d", e.free_memory, free_memory_o);
          errors++;
        end
        if (removed_count_o !== e.removed_count) begin
          $error("removed_count expected %0d got %0d", e.removed_count,
                 removed_count_o);
          errors++;
        end
        if (running_o !== e.running) begin
          $error("running expected %0d got %0d", e.running, running_o); errors++;
        end
      end
    end
  end

  // Drive one request from the falling edge until it is taken
  task automatic send_request(input row_t rq, input int idle_pct);
    result_t e;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start          <= 1'b1;
    action_i       <= rq.action;
    process_id_i   <= rq.id;
    process_size_i <= rq.size;
    lifetime_i     <= rq.life;
    elapsed_time_i <= rq.elapsed;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    e = apply_request(rq.action, rq.id, rq.size, rq.life, rq.elapsed);
    if (rq.typed) begin
      e.status = rq.status;
      e.position = rq.position;
      e.free_memory = rq.free_memory;
    end
    pending_results.push_back(e);
    @(negedge clk_i);
  endtask

  // Drain outstanding results, then update total memory
  task automatic write_total(input logic [15:0] value);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mem_total = value;
    @(negedge clk_i);
  endtask

  function automatic row_t random_request();
    row_t rq;
    int sel;
    rq = '{default: '0};
    sel = $urandom_range(99);
    rq.action = (sel < 45) ? bfsa_pkg::ActAlloc : (sel < 65) ? bfsa_pkg::ActFree :
                (sel < 85) ? bfsa_pkg::ActTime : bfsa_pkg::ActCompact;
    rq.id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(23));
    if (rq.action == bfsa_pkg::ActFree && seg_cnt > 0 && $urandom_range(3) != 0)
      rq.id = seg_owner[$urandom_range(seg_cnt - 1)];
    case ($urandom_range(9))
      0:       rq.size = 16'($urandom);
      1:       rq.size = 16'($urandom_range(4000));
      default: rq.size = 16'($urandom_range(40, 1));
    endcase
    rq.life    = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(120));
    rq.elapsed = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(25));
    return rq;
  endfunction

  row_t directed [$];
  int   idle_by_phase [4] = '{0, 69, 0, 8};
  logic [15:0] total_by_phase [4] = '{16'd65535, 16'd300, 16'd1, 16'd40000};

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    start = 1'b0;
    action_i = '0;
    process_id_i = '0;
    process_size_i = '0;
    lifetime_i = '0;
    elapsed_time_i = '0;
    mem_total = 16'd65535;
    seg_cnt = 0;
    mem_used = '0;

    // act, id, size, life, elapsed, typed, status, position, free
    directed = '{
      '{bfsa_pkg::ActCompact, 16'd0, 16'd0, 32'd0, 32'd0, 1,
        bfsa_pkg::StOk, 16'd0, 16'd65535},
      '{bfsa_pkg::ActTime, 16'd0, 16'd0, 32'd0, 32'd5, 1,
        bfsa_pkg::StOk, 16'd0, 16'd65535},
      '{bfsa_pkg::ActFree, 16'hFFFF, 16'd1, 32'd0, 32'd0, 1,
        bfsa_pkg::StNoId, 16'd0, 16'd65535},
      '{bfsa_pkg::ActAlloc, 16'd7, 16'd0, 32'd10, 32'd0, 1,
        bfsa_pkg::StNoFit, 16'd0, 16'd65535},
      '{bfsa_pkg::ActAlloc, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 1,
        bfsa_pkg::StOk, 16'd0, 16'd0},
      '{bfsa_pkg::ActAlloc, 16'd1, 16'd1, 32'd3, 32'd0, 1,
        bfsa_pkg::StNoFit, 16'd0, 16'd0},
      '{bfsa_pkg::ActAlloc, 16'd0, 16'd1, 32'd3, 32'd0, 1,
        bfsa_pkg::StDupId, 16'd0, 16'd0},
      '{bfsa_pkg::ActTime, 16'd0, 16'd0, 32'd0, 32'hFFFF_FFFE, 0,
        bfsa_pkg::StOk, 16'd0, 16'd0},
      '{bfsa_pkg::ActTime, 16'd0, 16'd0, 32'd0, 32'hFFFF_FFFF, 1,
        bfsa_pkg::StOk, 16'd0, 16'd65535},
      // best-fit placement with holes, coalescing by free and expiry, then compaction
      '{bfsa_pkg::ActAlloc, 16'd10, 16'd100, 32'd5, 32'd0, 0, bfsa_pkg::StOk, 0, 0},
      '{bfsa_pkg::ActAlloc, 16'd11, 16'd50, 32'd50, 32'd0, 0, bfsa_pkg::StOk, 0, 0},
      '{bfsa_pkg::ActAlloc, 16'd12, 16'd30, 32'd50, 32'd0, 0, bfsa_pkg::StOk, 0, 0},
      '{bfsa_pkg::ActAlloc, 16'd13, 16'd20, 32'd50, 32'd0, 0, bfsa_pkg::StOk, 0, 0},
      '{bfsa_pkg::ActFree, 16'd11, 16'd0, 32'd0, 32'd0, 0, bfsa_pkg::StOk, 0, 0},
      '{bfsa_pkg::ActAlloc, 16'd14, 16'd10, 32'd50, 32'd0, 0, bfsa_pkg::StOk, 0, 0},
      '{bfsa_pkg::ActTime, 16'd0, 16'd0, 32'd0, 32'd5, 0, bfsa_pkg::StOk, 0, 0},
      '{bfsa_pkg::ActAlloc, 16'd15, 16'd40, 32'd50, 32'd0, 0, bfsa_pkg::StOk, 0, 0},
      '{bfsa_pkg::ActCompact, 16'd0, 16'd0, 32'd0, 32'd0, 0, bfsa_pkg::StOk, 0, 0},
      '{bfsa_pkg::ActAlloc, 16'hFFFF, 16'd65000, 32'd1, 32'd0, 0, bfsa_pkg::StOk, 0, 0},
      '{bfsa_pkg::ActFree, 16'd12, 16'd0, 32'd0, 32'd0, 0, bfsa_pkg::StOk, 0, 0}
    };

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_request(directed[i], 0);

    // Random phases; memory size changes with segments still present
    for (int ph = 0; ph < 4; ph++) begin
      write_total(total_by_phase[ph]);
      repeat (150) send_request(random_request(), idle_by_phase[ph]);
    end
    // A tiny memory fills fast under random traffic
    write_total(16'd20);
    repeat (40) send_request(random_request(), 30);

    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: best_fit_segment_allocator_core.f
rtl/core/bfsa_pkg.sv
rtl/core/bfsa_cell.sv
rtl/core/best_fit_segment_allocator_core.sv
sim/best_fit_segment_allocator_core_test.sv
